@@ design/assert_macros.svh @@
// Assertion macros used by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define BFP_ASSERT_IMPL(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

`define BFP_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`else

`define BFP_ASSERT_IMPL(lbl, a, c, msg)

`define BFP_ASSERT_NEXT(lbl, a, c, msg)

`endif

`endif

@@ design/bfp_pkg.sv @@
package bfp_pkg;

	localparam int SLOT_COUNT = 96;
	localparam int TOKEN_LIMIT = 30;
	localparam int TOK_W = $clog2(TOKEN_LIMIT + 1);
	localparam int KEY_COUNT = 10;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_KEY = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;

	localparam logic [1:0] NUM_BEFORE = 2'd0;
	localparam logic [1:0] NUM_IN = 2'd1;
	localparam logic [1:0] NUM_DONE = 2'd2;

	localparam logic [3:0] KIND_SIZE = 4'd0;
	localparam logic [3:0] KIND_LINE_HEIGHT = 4'd1;
	localparam logic [3:0] KIND_GLYPH_SEL = 4'd2;
	localparam logic [3:0] KIND_XADVANCE = 4'd9;
	localparam logic [3:0] KIND_NONE = 4'd10;

	localparam logic [3:0] KEY_CHAR_ID = 4'd0;
	localparam logic [3:0] KEY_SIZE = 4'd1;
	localparam logic [3:0] KEY_LINE_HEIGHT = 4'd2;
	localparam logic [3:0] KEY_XADVANCE = 4'd9;

	localparam logic [0:0] REG_FIRST_CHAR = 1'd0;
	localparam logic [0:0] REG_ADVANCE_BIAS = 1'd1;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_EQUAL = 8'h3d;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [79:0] KEY_STR [KEY_COUNT] = '{
		"char id", "size", "lineHeight", "x", "y",
		"width", "height", "xoffset", "yoffset", "xadvance"
	};
	localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
		4'd7, 4'd4, 4'd10, 4'd1, 4'd1, 4'd5, 4'd6, 4'd7, 4'd7, 4'd8
	};

	typedef struct packed {
		logic valid;
		logic [3:0] kind;
		logic [6:0] slot;
		logic signed [31:0] value;
		logic last;
	} bfp_result_t;

	function automatic logic key_char_hit(input int k, input logic [TOK_W-1:0] pos,
			input logic [7:0] c);
		logic [79:0] s;
		logic [3:0] ln;
		logic [6:0] sh;
		logic hit;
		s = KEY_STR[k];
		ln = KEY_LEN[k];
		hit = 1'b0;
		if (pos < TOK_W'(ln)) begin
			sh = 7'((ln - 4'd1 - 4'(pos)) * 8);
			hit = (s[sh +: 8] == c);
		end
		return hit;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

endpackage

@@ design/bfp_parse.sv @@
module bfp_parse
	import bfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	input  logic [15:0] first_char,
	input  logic [7:0]  advance_bias,
	output bfp_result_t result
);

	logic [1:0] phase_q;
	logic in_comment_q;
	logic [TOK_W-1:0] key_len_q;
	logic [KEY_COUNT-1:0] key_flags_q;
	logic [TOK_W-1:0] val_chars_q;
	logic [1:0] num_phase_q;
	logic [31:0] num_val_q;
	logic num_neg_q;
	logic glyph_act_q;
	logic [6:0] glyph_slot_q;

	logic [1:0] phase_d;
	logic in_comment_d;
	logic [TOK_W-1:0] key_len_d;
	logic [KEY_COUNT-1:0] key_flags_d;
	logic [TOK_W-1:0] val_chars_d;
	logic [1:0] num_phase_d;
	logic [31:0] num_val_d;
	logic num_neg_d;
	logic glyph_act_d;
	logic [6:0] glyph_slot_d;

	logic cmt;
	logic [TOK_W-1:0] kf_len_in, kf_len;
	logic [KEY_COUNT-1:0] kf_flags_in, kf_flags;
	logic digit;
	logic [7:0] dval;
	logic [31:0] v10;
	logic [TOK_W-1:0] vf_chars;
	logic [1:0] vf_phase;
	logic [31:0] vf_val;
	logic vf_neg;
	logic do_finish;
	logic [31:0] fv;
	logic [3:0] hit;
	logic [32:0] diff;
	logic in_rng;
	logic [31:0] adv;
	logic wrote;
	logic [3:0] w_kind;
	logic [6:0] w_slot;
	logic [31:0] w_val;

	assign cmt = in_comment_q | (text_byte == CH_HASH);

	// Key character feed; a new key starts from a fresh match set.
	always_comb begin
		kf_len_in = (phase_q == PH_KEY) ? key_len_q : '0;
		kf_flags_in = (phase_q == PH_KEY) ? key_flags_q : '1;
		kf_len = kf_len_in;
		kf_flags = kf_flags_in;
		if (kf_len_in < TOK_W'(TOKEN_LIMIT)) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				if (!key_char_hit(k, kf_len_in, text_byte))
					kf_flags[k] = 1'b0;
			end
			kf_len = kf_len_in + TOK_W'(1);
		end
	end

	// Value character feed with the running decimal conversion.
	assign digit = (text_byte >= 8'd48) && (text_byte <= 8'd57);
	assign dval = text_byte - 8'd48;
	assign v10 = (num_val_q << 3) + (num_val_q << 1);

	always_comb begin
		vf_chars = val_chars_q;
		vf_phase = num_phase_q;
		vf_val = num_val_q;
		vf_neg = num_neg_q;
		if (val_chars_q < TOK_W'(TOKEN_LIMIT)) begin
			vf_chars = val_chars_q + TOK_W'(1);
			case (num_phase_q)
				NUM_BEFORE: begin
					if (digit) begin
						vf_phase = NUM_IN;
						vf_val = {24'd0, dval};
					end else if (text_byte == CH_MINUS) begin
						vf_phase = NUM_IN;
						vf_neg = 1'b1;
					end
				end
				NUM_IN: begin
					if (digit)
						vf_val = num_neg_q ? (v10 - {24'd0, dval}) : (v10 + {24'd0, dval});
					else
						vf_phase = NUM_DONE;
				end
				default: ;
			endcase
		end
	end

	// End of value: pick the key and form the write.
	assign do_finish = !cmt && (phase_q == PH_VALUE) && (is_space(text_byte) || end_of_text);
	assign fv = is_space(text_byte) ? num_val_q : vf_val;
	assign diff = {1'b0, fv} - {17'd0, first_char};
	assign in_rng = !diff[32] && (diff[31:0] < 32'(SLOT_COUNT));

	always_comb begin
		hit = 4'(KEY_COUNT);
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			if (key_flags_q[k] && (key_len_q == TOK_W'(KEY_LEN[k])))
				hit = 4'(k);
		end
	end

	always_comb begin
		adv = (hit == KEY_XADVANCE) ? (fv - {24'd0, advance_bias}) : fv;
		wrote = 1'b0;
		w_kind = KIND_NONE;
		w_slot = '0;
		w_val = '0;
		if (do_finish) begin
			if (hit == KEY_CHAR_ID) begin
				wrote = in_rng;
				w_kind = KIND_GLYPH_SEL;
				w_slot = diff[6:0];
				w_val = fv;
			end else if (hit == KEY_SIZE || hit == KEY_LINE_HEIGHT) begin
				wrote = 1'b1;
				w_kind = (hit == KEY_SIZE) ? KIND_SIZE : KIND_LINE_HEIGHT;
				w_val = fv;
			end else if (hit < 4'(KEY_COUNT) && glyph_act_q) begin
				wrote = 1'b1;
				w_kind = hit;
				w_slot = glyph_slot_q;
				w_val = {{16{adv[15]}}, adv[15:0]};
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		in_comment_d = in_comment_q;
		key_len_d = key_len_q;
		key_flags_d = key_flags_q;
		val_chars_d = val_chars_q;
		num_phase_d = num_phase_q;
		num_val_d = num_val_q;
		num_neg_d = num_neg_q;
		glyph_act_d = glyph_act_q;
		glyph_slot_d = glyph_slot_q;
		if (cmt) begin
			in_comment_d = (text_byte != CH_NEWLINE);
			if (phase_q == PH_KEY) begin
				key_len_d = kf_len;
				key_flags_d = kf_flags;
			end else if (phase_q == PH_VALUE) begin
				val_chars_d = vf_chars;
				num_phase_d = vf_phase;
				num_val_d = vf_val;
				num_neg_d = vf_neg;
			end
		end else if (phase_q == PH_IDLE) begin
			if (is_alpha(text_byte)) begin
				phase_d = PH_KEY;
				key_len_d = kf_len;
				key_flags_d = kf_flags;
			end
		end else if (phase_q == PH_KEY) begin
			if (text_byte == CH_EQUAL) begin
				phase_d = PH_VALUE;
				val_chars_d = '0;
				num_phase_d = NUM_BEFORE;
				num_val_d = '0;
				num_neg_d = 1'b0;
			end else begin
				key_len_d = kf_len;
				key_flags_d = kf_flags;
			end
		end else begin
			if (!is_space(text_byte)) begin
				val_chars_d = vf_chars;
				num_phase_d = vf_phase;
				num_val_d = vf_val;
				num_neg_d = vf_neg;
			end
			if (do_finish) begin
				phase_d = PH_IDLE;
				if (wrote && hit == KEY_CHAR_ID) begin
					glyph_act_d = 1'b1;
					glyph_slot_d = diff[6:0];
				end
			end
		end
		if (end_of_text) begin
			phase_d = PH_IDLE;
			in_comment_d = 1'b0;
			key_len_d = '0;
			key_flags_d = '1;
			val_chars_d = '0;
			num_phase_d = NUM_BEFORE;
			num_val_d = '0;
			num_neg_d = 1'b0;
			glyph_act_d = 1'b0;
			glyph_slot_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			in_comment_q <= 1'b0;
			key_len_q <= '0;
			key_flags_q <= '1;
			val_chars_q <= '0;
			num_phase_q <= NUM_BEFORE;
			num_val_q <= '0;
			num_neg_q <= 1'b0;
			glyph_act_q <= 1'b0;
			glyph_slot_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			in_comment_q <= in_comment_d;
			key_len_q <= key_len_d;
			key_flags_q <= key_flags_d;
			val_chars_q <= val_chars_d;
			num_phase_q <= num_phase_d;
			num_val_q <= num_val_d;
			num_neg_q <= num_neg_d;
			glyph_act_q <= glyph_act_d;
			glyph_slot_q <= glyph_slot_d;
		end
	end

	always_comb begin
		result.valid = step && (wrote || end_of_text);
		result.kind = wrote ? w_kind : KIND_NONE;
		result.slot = wrote ? w_slot : 7'd0;
		result.value = wrote ? w_val : 32'd0;
		result.last = end_of_text;
	end

endmodule

@@ design/bfp_out_reg.sv @@
module bfp_out_reg
	import bfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bfp_result_t result,
	output logic        can_load,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // glyph_index[6:0], field_value[38:7]
	output logic [3:0]  m_tuser,  // field_kind[3:0]
	output logic        m_tlast   // finished
);

	logic [3:0] kind_q;
	logic [6:0] slot_q;
	logic [31:0] value_q;

	assign can_load = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (result.valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			kind_q <= result.kind;
			slot_q <= result.slot;
			value_q <= result.value;
			m_tlast <= result.last;
		end
	end

	assign m_tdata = {1'b0, value_q, slot_q};
	assign m_tuser = kind_q;

endmodule

@@ design/bitmap_font_text_parser_core.sv @@
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tdata: text_byte[7:0]; tlast: end_of_text
// m_*      out        m_tvalid/m_tready  tdata: glyph_index, field_value; tuser: field_kind;
//                                        tlast: finished
// cfg_*    in         cfg_we             cfg_index selects register, cfg_data
//
// One byte is taken per cycle unless the output stalls; the parse of a byte spans the input
// register and the result register, where its result word is captured.
// Reset clears the parse state, the glyph selection and both registers to defaults.
// A result waiting on m_tready stalls the parse stage and holds s_tready low while the
// input register is full; an empty input register still takes one byte.
`include "assert_macros.svh"

module bitmap_font_text_parser_core
	import bfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // text_byte[7:0]
	input  logic        s_tlast,  // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // glyph_index[6:0], field_value[38:7]
	output logic [3:0]  m_tuser,  // field_kind[3:0]
	output logic        m_tlast,  // finished
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic [15:0] first_char_q;
	logic [7:0] advance_bias_q;
	logic can_load;
	logic step;
	bfp_result_t result;
	logic none_word;
	logic plain_word;

	assign step = valid_s1 && can_load;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_char_q <= 16'd32;
			advance_bias_q <= 8'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_CHAR: first_char_q <= cfg_data;
				REG_ADVANCE_BIAS: advance_bias_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	bfp_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.text_byte(byte_s1),
		.end_of_text(last_s1),
		.first_char(first_char_q),
		.advance_bias(advance_bias_q),
		.result(result)
	);

	bfp_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.result(result),
		.can_load(can_load),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	assign none_word = (m_tuser == KIND_NONE);
	assign plain_word = (m_tuser == KIND_SIZE) || (m_tuser == KIND_LINE_HEIGHT) || none_word;

	`BFP_ASSERT_IMPL(a_ready_when_empty, !valid_s1, s_tready, "input stage empty but not ready")
	`BFP_ASSERT_NEXT(a_last_gives_result, step && last_s1, m_tvalid && m_tlast, "no final word")
	`BFP_ASSERT_IMPL(a_none_only_last, m_tvalid && none_word, m_tlast, "empty word before the end")
	`BFP_ASSERT_IMPL(a_plain_slot_zero, m_tvalid && plain_word, m_tdata[6:0] == 7'd0, "slot set")

endmodule
